@@ rtl/core/gf2rd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gf2rd_pkg
// shared types and constants of the gf2 row dependency finder
// ----------------------------------------------------------------------------
package gf2rd_pkg;

    localparam int MAX_ROWS  = 64;
    localparam int MAX_COLS  = 64;
    localparam int DEPS_CAP  = 64;

    localparam int ENTRY_W   = 6;
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 2;
    localparam int MASK_W    = 64;

    localparam int ROW_W     = $clog2(MAX_ROWS);
    localparam int COL_W     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ROW_CNT_W = $clog2(MAX_ROWS + 1);
    localparam int COL_CNT_W = $clog2(MAX_COLS + 1);
    localparam int LIM_W     = $clog2(DEPS_CAP + 1);

    localparam int CMP_A     = (ENTRY_W + 1 > ROW_CNT_W) ? ENTRY_W + 1 : ROW_CNT_W;
    localparam int CMP_B     = (CFG_W > COL_CNT_W) ? CFG_W : COL_CNT_W;
    localparam int CMP_W     = (CMP_A > CMP_B) ? CMP_A : CMP_B;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROWS_IN_USE = 2'd0,
        CFG_COLS_IN_USE = 2'd1,
        CFG_DEPS_CAP    = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [MAX_ROWS-1:0] ident;
        logic [MAX_COLS-1:0] mat;
    } aug_row_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_ROW,
        WR_PIV,
        WR_XOR
    } wr_sel_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_START,
        ST_SRCH_RD,
        ST_SRCH_CHK,
        ST_SWAP_RD,
        ST_SWAP_WR_F,
        ST_SWAP_WR_P,
        ST_ELIM,
        ST_NEXT_COL,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic                 ld_accept;
        logic                 rd_en;
        logic [ROW_W-1:0]     rd_addr;
        wr_sel_t              wr_sel;
        logic [ROW_W-1:0]     wr_addr;
        logic [COL_W-1:0]     col_idx;
        logic [COL_CNT_W-1:0] col_lim;
        logic                 piv_load;
        logic                 pend_load;
        logic                 out_push;
        logic                 out_dep_valid;
        logic                 out_last;
        logic                 clear_store;
    } dp_cmd_t;

    typedef struct packed {
        logic rd_bit;
        logic rd_dep;
        logic out_busy;
    } dp_status_t;

endpackage

@@ rtl/core/gf2rd_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gf2rd_dp
// row store, load merge, pivot and pending rows, result register
// ----------------------------------------------------------------------------
module gf2rd_dp
    import gf2rd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  dp_cmd_t              cmd,
    output dp_status_t           status,
    input  logic [ENTRY_W-1:0]   entry_row,
    input  logic [ENTRY_W-1:0]   entry_col,
    input  logic                 entry_valid,
    input  logic [ROW_CNT_W-1:0] m_cur,
    input  logic [COL_CNT_W-1:0] n_cur,
    input  logic                 m_ready,
    output logic                 m_valid,
    output logic [MASK_W-1:0]    m_dependency_mask,
    output logic                 m_dep_valid,
    output logic                 m_last_result
);

    aug_row_t            mem [MAX_ROWS];
    logic [MAX_ROWS-1:0] row_vld_reg;

    aug_row_t            rd_data_reg;
    logic                rd_vld_reg;
    logic [ROW_W-1:0]    rd_addr_reg;

    logic                ld_wr_reg;
    logic [ROW_W-1:0]    ld_row_reg;
    logic [COL_W-1:0]    ld_col_reg;

    aug_row_t            piv_row_reg;
    logic [MAX_ROWS-1:0] pend_reg;

    logic                out_valid_reg;
    logic [MASK_W-1:0]   out_mask_reg;
    logic                out_depv_reg;
    logic                out_last_reg;

    aug_row_t            rd_row;
    aug_row_t            rd_row_m;
    aug_row_t            ld_data;
    aug_row_t            wr_data;
    logic                wr_en;
    logic [ROW_W-1:0]    wr_addr;
    logic                rd_en;
    logic [ROW_W-1:0]    rd_addr;
    logic [MAX_COLS-1:0] col_keep;
    logic                ld_hit;

    // rows never written read as their identity row
    always_comb begin
        if (rd_vld_reg) begin
            rd_row = rd_data_reg;
        end else begin
            rd_row.ident = MAX_ROWS'(1) << rd_addr_reg;
            rd_row.mat   = '0;
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_COLS; i++) begin
            col_keep[i] = (COL_CNT_W'(i) < cmd.col_lim);
        end
        rd_row_m.ident = rd_row.ident;
        rd_row_m.mat   = rd_row.mat & col_keep;
    end

    assign ld_hit = entry_valid
                 && (CMP_W'(entry_row) < CMP_W'(m_cur))
                 && (CMP_W'(entry_col) < CMP_W'(n_cur));

    always_comb begin
        ld_data.ident = rd_row.ident;
        ld_data.mat   = rd_row.mat | (MAX_COLS'(1) << ld_col_reg);
    end

    // single write port: the pending load write or a commanded write
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = cmd.wr_addr;
        wr_data = rd_row_m;
        if (ld_wr_reg) begin
            wr_en   = 1'b1;
            wr_addr = ld_row_reg;
            wr_data = ld_data;
        end else begin
            case (cmd.wr_sel)
                WR_ROW: begin
                    wr_en   = 1'b1;
                    wr_data = rd_row_m;
                end
                WR_PIV: begin
                    wr_en   = 1'b1;
                    wr_data = piv_row_reg;
                end
                WR_XOR: begin
                    wr_en   = 1'b1;
                    wr_data = rd_row_m ^ piv_row_reg;
                end
                default: begin
                    wr_en   = 1'b0;
                end
            endcase
        end
    end

    assign rd_en   = cmd.ld_accept | cmd.rd_en;
    assign rd_addr = cmd.ld_accept ? ROW_W'(entry_row) : cmd.rd_addr;

    // store with registered read, write data bypassed on a same-row read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_addr_reg <= rd_addr;
            if (wr_en && (wr_addr == rd_addr)) begin
                rd_data_reg <= wr_data;
                rd_vld_reg  <= 1'b1;
            end else begin
                rd_data_reg <= mem[rd_addr];
                rd_vld_reg  <= row_vld_reg[rd_addr];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_vld_reg <= '0;
        end else if (cmd.clear_store) begin
            row_vld_reg <= '0;
        end else if (wr_en) begin
            row_vld_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ld_wr_reg <= 1'b0;
        end else begin
            ld_wr_reg <= cmd.ld_accept && ld_hit;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.ld_accept) begin
            ld_row_reg <= ROW_W'(entry_row);
            ld_col_reg <= COL_W'(entry_col);
        end
        if (cmd.piv_load) begin
            piv_row_reg <= rd_row_m;
        end
        if (cmd.pend_load) begin
            pend_reg <= rd_row_m.ident;
        end
        if (cmd.out_push) begin
            out_mask_reg <= cmd.out_dep_valid ? MASK_W'(pend_reg) : '0;
            out_depv_reg <= cmd.out_dep_valid;
            out_last_reg <= cmd.out_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_push) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.rd_bit   = rd_row_m.mat[cmd.col_idx];
    assign status.rd_dep   = (rd_row_m.mat == '0) && (rd_row_m.ident != '0);
    assign status.out_busy = out_valid_reg && !m_ready;

    assign m_valid           = out_valid_reg;
    assign m_dependency_mask = out_mask_reg;
    assign m_dep_valid       = out_depv_reg;
    assign m_last_result     = out_last_reg;

endmodule

@@ rtl/core/gf2rd_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gf2rd_ctrl
// sequencer for load, pivot search, swap, elimination and result scan
// ----------------------------------------------------------------------------
module gf2rd_ctrl
    import gf2rd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_last_entry,
    output logic                 s_ready,
    input  logic [ROW_CNT_W-1:0] m_cur,
    input  logic [COL_CNT_W-1:0] n_cur,
    input  logic [LIM_W-1:0]     lim_cur,
    output dp_cmd_t              cmd,
    input  dp_status_t           status
);

    ctrl_state_t          state_reg, state_next;
    logic [ROW_CNT_W-1:0] m_reg, m_next;
    logic [COL_CNT_W-1:0] n_reg, n_next;
    logic [LIM_W-1:0]     lim_reg, lim_next;
    logic [COL_CNT_W-1:0] col_reg, col_next;
    logic [ROW_CNT_W-1:0] piv_reg, piv_next;
    logic [ROW_CNT_W-1:0] r_reg, r_next;
    logic [ROW_W-1:0]     found_reg, found_next;
    logic                 wp_reg, wp_next;
    logic [ROW_W-1:0]     wa_reg, wa_next;
    logic                 have_pend_reg, have_pend_next;
    logic [LIM_W-1:0]     emit_reg, emit_next;
    logic                 accept;

    assign accept = s_valid && (state_reg == ST_LOAD);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_LOAD;
            have_pend_reg <= 1'b0;
            wp_reg        <= 1'b0;
        end else begin
            state_reg     <= state_next;
            have_pend_reg <= have_pend_next;
            wp_reg        <= wp_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_reg     <= m_next;
        n_reg     <= n_next;
        lim_reg   <= lim_next;
        col_reg   <= col_next;
        piv_reg   <= piv_next;
        r_reg     <= r_next;
        found_reg <= found_next;
        wa_reg    <= wa_next;
        emit_reg  <= emit_next;
    end

    // next state and counters
    always_comb begin
        state_next     = state_reg;
        m_next         = m_reg;
        n_next         = n_reg;
        lim_next       = lim_reg;
        col_next       = col_reg;
        piv_next       = piv_reg;
        r_next         = r_reg;
        found_next     = found_reg;
        wp_next        = wp_reg;
        wa_next        = wa_reg;
        have_pend_next = have_pend_reg;
        emit_next      = emit_reg;
        case (state_reg)
            ST_LOAD: begin
                if (accept && s_last_entry) begin
                    m_next     = m_cur;
                    n_next     = n_cur;
                    lim_next   = lim_cur;
                    state_next = ST_START;
                end
            end
            ST_START: begin
                col_next  = '0;
                piv_next  = '0;
                r_next    = '0;
                emit_next = '0;
                if ((m_reg == '0) || (n_reg == '0) || (lim_reg == '0)) begin
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_SRCH_RD;
                end
            end
            ST_SRCH_RD: begin
                state_next = ST_SRCH_CHK;
            end
            ST_SRCH_CHK: begin
                if (status.rd_bit) begin
                    found_next = r_reg[ROW_W-1:0];
                    if (r_reg == piv_reg) begin
                        r_next     = '0;
                        wp_next    = 1'b0;
                        state_next = ST_ELIM;
                    end else begin
                        state_next = ST_SWAP_RD;
                    end
                end else begin
                    r_next = r_reg + 1'b1;
                    if (r_reg + 1'b1 == m_reg) begin
                        state_next = ST_NEXT_COL;
                    end else begin
                        state_next = ST_SRCH_RD;
                    end
                end
            end
            ST_SWAP_RD: begin
                state_next = ST_SWAP_WR_F;
            end
            ST_SWAP_WR_F: begin
                state_next = ST_SWAP_WR_P;
            end
            ST_SWAP_WR_P: begin
                r_next     = '0;
                wp_next    = 1'b0;
                state_next = ST_ELIM;
            end
            ST_ELIM: begin
                if (r_reg < m_reg) begin
                    wa_next = r_reg[ROW_W-1:0];
                    wp_next = 1'b1;
                    r_next  = r_reg + 1'b1;
                end else begin
                    wp_next = 1'b0;
                    if (!wp_reg) begin
                        piv_next   = piv_reg + 1'b1;
                        state_next = ST_NEXT_COL;
                    end
                end
            end
            ST_NEXT_COL: begin
                col_next = col_reg + 1'b1;
                if ((col_reg + 1'b1 >= n_reg) || (piv_reg >= m_reg)) begin
                    r_next     = '0;
                    state_next = ST_SCAN_RD;
                end else begin
                    r_next     = piv_reg;
                    state_next = ST_SRCH_RD;
                end
            end
            ST_SCAN_RD: begin
                state_next = ST_SCAN_CHK;
            end
            ST_SCAN_CHK: begin
                if (status.rd_dep) begin
                    if (!(have_pend_reg && status.out_busy)) begin
                        have_pend_next = 1'b1;
                        emit_next      = emit_reg + 1'b1;
                        r_next         = r_reg + 1'b1;
                        if ((emit_reg + 1'b1 == lim_reg) || (r_reg + 1'b1 == m_reg)) begin
                            state_next = ST_FINISH;
                        end else begin
                            state_next = ST_SCAN_RD;
                        end
                    end
                end else begin
                    r_next = r_reg + 1'b1;
                    if (r_reg + 1'b1 == m_reg) begin
                        state_next = ST_FINISH;
                    end else begin
                        state_next = ST_SCAN_RD;
                    end
                end
            end
            ST_FINISH: begin
                if (!status.out_busy) begin
                    have_pend_next = 1'b0;
                    state_next     = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // datapath commands
    always_comb begin
        cmd               = '0;
        cmd.wr_sel        = WR_NONE;
        cmd.col_idx       = col_reg[COL_W-1:0];
        cmd.col_lim       = n_reg;
        cmd.rd_addr       = r_reg[ROW_W-1:0];
        cmd.wr_addr       = wa_reg;
        s_ready           = 1'b0;
        case (state_reg)
            ST_LOAD: begin
                s_ready       = 1'b1;
                cmd.ld_accept = accept;
            end
            ST_SRCH_RD: begin
                cmd.rd_en = 1'b1;
            end
            ST_SRCH_CHK: begin
                cmd.piv_load = status.rd_bit;
            end
            ST_SWAP_RD: begin
                cmd.rd_en   = 1'b1;
                cmd.rd_addr = piv_reg[ROW_W-1:0];
            end
            ST_SWAP_WR_F: begin
                cmd.wr_sel  = WR_ROW;
                cmd.wr_addr = found_reg;
            end
            ST_SWAP_WR_P: begin
                cmd.wr_sel  = WR_PIV;
                cmd.wr_addr = piv_reg[ROW_W-1:0];
            end
            ST_ELIM: begin
                cmd.rd_en = (r_reg < m_reg);
                if (wp_reg && status.rd_bit && (wa_reg != piv_reg[ROW_W-1:0])) begin
                    cmd.wr_sel = WR_XOR;
                end
            end
            ST_SCAN_RD: begin
                cmd.rd_en = 1'b1;
            end
            ST_SCAN_CHK: begin
                if (status.rd_dep && !(have_pend_reg && status.out_busy)) begin
                    cmd.pend_load     = 1'b1;
                    cmd.out_push      = have_pend_reg;
                    cmd.out_dep_valid = 1'b1;
                    cmd.out_last      = 1'b0;
                end
            end
            ST_FINISH: begin
                if (!status.out_busy) begin
                    cmd.out_push      = 1'b1;
                    cmd.out_dep_valid = have_pend_reg;
                    cmd.out_last      = 1'b1;
                    cmd.clear_store   = 1'b1;
                end
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

@@ rtl/core/gf2_row_dependency_finder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gf2_row_dependency_finder
// left null space of a gf2 matrix by gauss-jordan elimination
// ----------------------------------------------------------------------------
// Entries of a GF(2) matrix arrive one word per cycle, each setting one bit
// of a 64-row store (read-modify-write with bypass, so repeated rows stream
// at full rate). The word flagged last_entry starts elimination and s_ready
// drops until the answer has been handed to the result register. Elimination
// shares the store's single write port: for each column it runs a pivot
// search row by row, a swap when the pivot is found below the pivot row, a
// clearing pass over all rows and the step to the next column; the final
// scan reads row by row and stalls on m_ready while a result is waiting.
// Dependencies come out in row order, the last one flagged by last_result;
// an empty answer is a single word with dep_valid low. The store is wiped
// through its per-row valid bits after each answer, so there is no clearing
// pass after reset. Configuration must be written only while the block is
// idle, which the block leaves to the user.
// ----------------------------------------------------------------------------
module gf2_row_dependency_finder
    import gf2rd_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // configuration writes
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]     cfg_wdata,
    // entry words
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [ENTRY_W-1:0]   s_entry_row,
    input  logic [ENTRY_W-1:0]   s_entry_col,
    input  logic                 s_entry_valid,
    input  logic                 s_last_entry,
    // result words
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [MASK_W-1:0]    m_dependency_mask,
    output logic                 m_dep_valid,
    output logic                 m_last_result
);

    logic [CFG_W-1:0]     rows_reg;
    logic [CFG_W-1:0]     cols_reg;
    logic [CFG_W-1:0]     maxd_reg;

    logic [ROW_CNT_W-1:0] m_cur;
    logic [COL_CNT_W-1:0] n_cur;
    logic [LIM_W-1:0]     lim_cur;

    dp_cmd_t              cmd;
    dp_status_t           status;

    // configuration registers, reset to the full array
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg <= CFG_W'(64);
            cols_reg <= CFG_W'(64);
            maxd_reg <= CFG_W'(64);
        end else if (cfg_we) begin
            case (cfg_idx_t'(cfg_addr))
                CFG_ROWS_IN_USE: rows_reg <= cfg_wdata;
                CFG_COLS_IN_USE: cols_reg <= cfg_wdata;
                CFG_DEPS_CAP:    maxd_reg <= cfg_wdata;
                default: begin
                    rows_reg <= rows_reg;
                end
            endcase
        end
    end

    // oversized settings saturate to what the store holds
    assign m_cur   = (CMP_W'(rows_reg) > CMP_W'(MAX_ROWS)) ? ROW_CNT_W'(MAX_ROWS)
                                                          : ROW_CNT_W'(rows_reg);
    assign n_cur   = (CMP_W'(cols_reg) > CMP_W'(MAX_COLS)) ? COL_CNT_W'(MAX_COLS)
                                                          : COL_CNT_W'(cols_reg);
    assign lim_cur = (CMP_W'(maxd_reg) > CMP_W'(DEPS_CAP)) ? LIM_W'(DEPS_CAP)
                                                          : LIM_W'(maxd_reg);

    // sequencer
    gf2rd_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_last_entry (s_last_entry),
        .s_ready      (s_ready),
        .m_cur        (m_cur),
        .n_cur        (n_cur),
        .lim_cur      (lim_cur),
        .cmd          (cmd),
        .status       (status)
    );

    // row store and result register
    gf2rd_dp u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cmd               (cmd),
        .status            (status),
        .entry_row         (s_entry_row),
        .entry_col         (s_entry_col),
        .entry_valid       (s_entry_valid),
        .m_cur             (m_cur),
        .n_cur             (n_cur),
        .m_ready           (m_ready),
        .m_valid           (m_valid),
        .m_dependency_mask (m_dependency_mask),
        .m_dep_valid       (m_dep_valid),
        .m_last_result     (m_last_result)
    );

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the gf2 row dependency finder
// ----------------------------------------------------------------------------
// Loads GF(2) matrices entry by entry through the s_ channel and checks every
// dependency word on the m_ channel against a local Gauss-Jordan solver.
// A short directed part covers the field extremes, repeated, invalid and
// out-of-range entries, empty answers, oversized registers, a zero
// dependency limit and a shape change in the middle of a matrix. Random
// matrices follow, mostly small, with a few at full size. The sender works
// in bursts and the receiver stalls in changing patterns.
// ----------------------------------------------------------------------------
module tb
    import gf2rd_pkg::*;
();

    localparam int QUIET_LIMIT  = 60000;  // idle cycles before giving up
    localparam int SETTLE_TICKS = 8;      // load pipeline drain before writes
    localparam int WORD_BUDGET  = 480;

    typedef struct packed {
        logic [MASK_W-1:0] mask;
        logic              dep_valid;
        logic              last_result;
    } dep_word_t;

    typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_PULSE} rx_mode_t;

    // ------------------------------------------------------------------------
    // dependency solver and store of awaited words
    // ------------------------------------------------------------------------
    class dependency_board;
        logic [MAX_COLS-1:0] loaded [MAX_ROWS];
        logic [CFG_W-1:0]    rows_reg;
        logic [CFG_W-1:0]    cols_reg;
        logic [CFG_W-1:0]    deps_reg;
        dep_word_t           awaited [$];
        int                  mismatches;

        function new();
            foreach (loaded[i]) loaded[i] = '0;
            rows_reg   = 7'd64;
            cols_reg   = 7'd64;
            deps_reg   = 7'd64;
            mismatches = 0;
        endfunction

        function int eff_rows();
            return (rows_reg > MAX_ROWS) ? MAX_ROWS : int'(rows_reg);
        endfunction

        function int eff_cols();
            return (cols_reg > MAX_COLS) ? MAX_COLS : int'(cols_reg);
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void write_reg(cfg_idx_t idx, logic [CFG_W-1:0] value);
            case (idx)
                CFG_ROWS_IN_USE: rows_reg = value;
                CFG_COLS_IN_USE: cols_reg = value;
                CFG_DEPS_CAP:    deps_reg = value;
                default: ;
            endcase
        endfunction

        // accepted entry word; on the closing word solve and queue the answer
        function void take_entry(logic [ENTRY_W-1:0] row, logic [ENTRY_W-1:0] col,
                                 logic ev, logic lst);
            int m, n, lim, piv, found, r, c;
            logic [MAX_COLS-1:0] keep, tmat;
            logic [MAX_ROWS-1:0] tid;
            logic [MAX_COLS-1:0] mat [MAX_ROWS];
            logic [MAX_ROWS-1:0] ident [MAX_ROWS];
            dep_word_t           answer [$];
            dep_word_t           w;
            m   = eff_rows();
            n   = eff_cols();
            lim = (deps_reg > DEPS_CAP) ? DEPS_CAP : int'(deps_reg);
            if (ev && row < m && col < n) loaded[row][col] = 1'b1;
            if (!lst) return;

            if (m != 0 && n != 0) begin
                keep = (n >= MAX_COLS) ? '1 : ((MAX_COLS'(1) << n) - 1'b1);
                for (r = 0; r < m; r++) begin
                    ident[r] = MAX_ROWS'(1) << r;
                    mat[r]   = loaded[r] & keep;
                end
                piv = 0;
                for (c = 0; c < n && piv < m; c++) begin
                    found = m;
                    for (r = piv; r < m; r++)
                        if (found == m && mat[r][c]) found = r;
                    if (found != m) begin
                        tmat = mat[found];   tid = ident[found];
                        mat[found]   = mat[piv];   ident[found] = ident[piv];
                        mat[piv]     = tmat;       ident[piv]   = tid;
                        for (r = 0; r < m; r++) begin
                            if (r != piv && mat[r][c]) begin
                                mat[r]   ^= mat[piv];
                                ident[r] ^= ident[piv];
                            end
                        end
                        piv++;
                    end
                end
                for (r = 0; r < m && answer.size() < lim; r++) begin
                    if (mat[r] == '0 && ident[r] != '0) begin
                        w.mask        = ident[r];
                        w.dep_valid   = 1'b1;
                        w.last_result = 1'b0;
                        answer.insert(answer.size(), w);
                    end
                end
            end

            if (answer.size() == 0) begin
                w.mask        = '0;
                w.dep_valid   = 1'b0;
                w.last_result = 1'b1;
                answer.insert(answer.size(), w);
            end else begin
                answer[answer.size()-1].last_result = 1'b1;
            end
            foreach (answer[i]) awaited.insert(awaited.size(), answer[i]);
            foreach (loaded[i]) loaded[i] = '0;
        endfunction

        function void check_dependency(logic [MASK_W-1:0] mask, logic dv, logic lr);
            dep_word_t want;
            if (awaited.size() == 0) begin
                $error("word with none awaited: dependency_mask %h dep_valid %b last_result %b",
                       mask, dv, lr);
                mismatches++;
                return;
            end
            want = awaited.pop_front();
            if (mask !== want.mask) begin
                $error("dependency_mask: expected %h, got %h", want.mask, mask);
                mismatches++;
            end
            if (dv !== want.dep_valid) begin
                $error("dep_valid: expected %b, got %b", want.dep_valid, dv);
                mismatches++;
            end
            if (lr !== want.last_result) begin
                $error("last_result: expected %b, got %b", want.last_result, lr);
                mismatches++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // signals
    // ------------------------------------------------------------------------
    logic                 aclk          = 1'b0;
    logic                 aresetn       = 1'b0;
    logic                 cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_addr      = CFG_ROWS_IN_USE;
    logic [CFG_W-1:0]     cfg_wdata     = '0;
    logic                 s_valid       = 1'b0;
    logic                 s_ready;
    logic [ENTRY_W-1:0]   s_entry_row   = '0;
    logic [ENTRY_W-1:0]   s_entry_col   = '0;
    logic                 s_entry_valid = 1'b0;
    logic                 s_last_entry  = 1'b0;
    logic                 m_valid;
    logic                 m_ready       = 1'b0;
    logic [MASK_W-1:0]    m_dependency_mask;
    logic                 m_dep_valid;
    logic                 m_last_result;

    dependency_board sb;
    int              burst_left   = 0;
    int              useful_words = 0;
    int              quiet_ticks  = 0;
    rx_mode_t        rx_mode      = RX_OPEN;
    int              rx_left      = 0;

    gf2_row_dependency_finder DUT (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_we            (cfg_we),
        .cfg_addr          (cfg_addr),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_entry_row       (s_entry_row),
        .s_entry_col       (s_entry_col),
        .s_entry_valid     (s_entry_valid),
        .s_last_entry      (s_last_entry),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_dependency_mask (m_dependency_mask),
        .m_dep_valid       (m_dep_valid),
        .m_last_result     (m_last_result)
    );

    // 12 ns clock
    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // receiver: ready pattern is redrawn at random whenever its run count expires
    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode = rx_mode_t'($urandom_range(0, 3));
            rx_left = $urandom_range(16, 96);
        end
        rx_left--;
        case (rx_mode)
            RX_OPEN:   m_ready <= 1'b1;
            RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
            RX_PULSE:  m_ready <= ((rx_left % 8) < 2);
            default:   m_ready <= 1'b1;
        endcase
    end

    // result monitor, values seen here are the ones the edge used
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_dependency(m_dependency_mask, m_dep_valid, m_last_result);
    end

    // watchdog: too long without any word moving means the block is stuck
    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || cfg_we)
                quiet_ticks = 0;
            else
                quiet_ticks++;
            if (quiet_ticks >= QUIET_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------------

    // one entry word, with burst gaps ahead of it now and then
    task automatic put_word(input logic [ENTRY_W-1:0] row, input logic [ENTRY_W-1:0] col,
                            input logic ev, input logic lst);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                @(negedge aclk);
                s_valid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        burst_left--;
        @(negedge aclk);
        s_valid       <= 1'b1;
        s_entry_row   <= row;
        s_entry_col   <= col;
        s_entry_valid <= ev;
        s_last_entry  <= lst;
        do @(posedge aclk); while (!s_ready);
        // every accepted word counts towards the budget
        useful_words++;
        sb.take_entry(row, col, ev, lst);
    endtask

    // hold the sender until every awaited word is in, then let the load
    // pipeline settle so the block is idle for register writes
    task automatic quiesce();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (SETTLE_TICKS) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        sb.write_reg(idx, value);
    endtask

    task automatic reshape(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] cols,
                           input logic [CFG_W-1:0] deps);
        quiesce();
        write_reg(CFG_ROWS_IN_USE, rows);
        write_reg(CFG_COLS_IN_USE, cols);
        write_reg(CFG_DEPS_CAP, deps);
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    // mostly small shapes, now and then an extreme one
    task automatic random_shape();
        int               sel;
        logic [CFG_W-1:0] rw, cw, dw;
        sel = $urandom_range(0, 19);
        case (sel)
            0: begin
                rw = $urandom_range(0, 1) ? 7'd0 : 7'($urandom_range(1, 8));
                cw = (rw == 0) ? 7'($urandom_range(0, 16)) : 7'd0;
            end
            1: begin
                rw = 7'd64;
                cw = 7'd64;
            end
            2: begin
                rw = 7'($urandom_range(65, 127));
                cw = 7'($urandom_range(1, 127));
            end
            3: begin
                // tall and narrow, lots of dependencies
                rw = 7'($urandom_range(17, 64));
                cw = 7'($urandom_range(1, 8));
            end
            default: begin
                rw = 7'($urandom_range(1, 16));
                cw = 7'($urandom_range(1, 16));
            end
        endcase
        sel = $urandom_range(0, 9);
        case (sel)
            0:       dw = 7'd0;
            1:       dw = 7'd1;
            2:       dw = 7'($urandom_range(65, 127));
            default: dw = 7'($urandom_range(2, 64));
        endcase
        reshape(rw, cw, dw);
    endtask

    // one matrix: mostly well-formed entries, sometimes pure noise
    task automatic random_matrix();
        int                 k, m, n;
        logic [ENTRY_W-1:0] row, col;
        logic               ev;
        m = sb.eff_rows();
        n = sb.eff_cols();
        if ($urandom_range(0, 9) == 0 || m == 0 || n == 0) begin
            k = $urandom_range(1, 12);
            for (int i = 0; i < k; i++)
                put_word(ENTRY_W'($urandom), ENTRY_W'($urandom), 1'($urandom_range(0, 1)),
                         i == k - 1);
        end else begin
            k = $urandom_range(0, m + n);
            for (int i = 0; i < k; i++) begin
                if ($urandom_range(0, 9) == 0) begin
                    row = ENTRY_W'($urandom);
                    col = ENTRY_W'($urandom);
                end else begin
                    row = ENTRY_W'($urandom_range(0, m - 1));
                    col = ENTRY_W'($urandom_range(0, n - 1));
                end
                ev = ($urandom_range(0, 15) != 0);
                put_word(row, col, ev, 1'b0);
            end
            // closing word either carries an entry or is empty
            if ($urandom_range(0, 3) == 0)
                put_word(ENTRY_W'($urandom), ENTRY_W'($urandom), 1'b0, 1'b1);
            else
                put_word(ENTRY_W'($urandom_range(0, m - 1)), ENTRY_W'($urandom_range(0, n - 1)),
                         1'b1, 1'b1);
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        sb = new();
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        // reset shape: corners, a repeated entry, an invalid entry
        put_word(6'd0, 6'd0, 1'b1, 1'b0);
        put_word(6'd63, 6'd63, 1'b1, 1'b0);
        put_word(6'd1, 6'd0, 1'b1, 1'b0);
        put_word(6'd1, 6'd0, 1'b1, 1'b0);
        put_word(6'd62, 6'd63, 1'b1, 1'b0);
        put_word(6'd5, 6'd5, 1'b0, 1'b0);
        put_word(6'd2, 6'd0, 1'b1, 1'b1);

        // empty marker on a full-size store: every row is its own dependency
        put_word(6'd63, 6'd63, 1'b0, 1'b1);

        // small shape with entries just outside it
        reshape(7'd4, 7'd3, 7'd64);
        put_word(6'd4, 6'd0, 1'b1, 1'b0);
        put_word(6'd63, 6'd0, 1'b1, 1'b0);
        put_word(6'd0, 6'd3, 1'b1, 1'b0);
        put_word(6'd0, 6'd63, 1'b1, 1'b0);
        put_word(6'd0, 6'd0, 1'b1, 1'b0);
        put_word(6'd1, 6'd1, 1'b1, 1'b0);
        put_word(6'd2, 6'd2, 1'b1, 1'b0);
        put_word(6'd3, 6'd0, 1'b1, 1'b1);

        // no rows, then no columns, then no dependencies allowed
        reshape(7'd0, 7'd5, 7'd64);
        put_word(6'd0, 6'd0, 1'b1, 1'b1);
        reshape(7'd5, 7'd0, 7'd64);
        put_word(6'd0, 6'd0, 1'b1, 1'b1);
        reshape(7'd8, 7'd8, 7'd0);
        put_word(6'd0, 6'd0, 1'b1, 1'b1);

        // oversized registers saturate
        reshape(7'd127, 7'd127, 7'd127);
        put_word(6'd63, 6'd63, 1'b1, 1'b0);
        put_word(6'd0, 6'd63, 1'b0, 1'b1);

        // shape changed between loading and the closing word
        reshape(7'd3, 7'd3, 7'd2);
        put_word(6'd2, 6'd2, 1'b1, 1'b0);
        put_word(6'd0, 6'd1, 1'b1, 1'b0);
        reshape(7'd6, 7'd2, 7'd1);
        put_word(6'd5, 6'd1, 1'b1, 1'b0);
        put_word(6'd4, 6'd0, 1'b1, 1'b1);

        // random matrices, shape changed on about a third of them
        while (useful_words < WORD_BUDGET) begin
            if ($urandom_range(0, 2) == 0)
                random_shape();
            random_matrix();
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);

        if (sb.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
